// ===== rtl/core/encoder_angle_velocity_assert.svh =====
// ----------------------------------------------------------------------------
// Encoder angle/velocity assertion macros
// Concurrent check helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ANGLE_VELOCITY_ASSERT_SVH
`define ENCODER_ANGLE_VELOCITY_ASSERT_SVH

`ifndef SYNTHESIS

`define EAV_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("encoder_angle_velocity: check failed");

`define EAV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("encoder_angle_velocity: sequencing check failed");

`else

`define EAV_ASSERT(lbl, expr)

`define EAV_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/eav_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder angle/velocity package
// Widths and fixed-point constants shared by the encoder datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package eav_pkg;

    localparam int POSITION_BITS = 14;
    localparam int TIME_BITS     = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int VEL_BITS      = 21;

    // accumulator holds position * floor(pi * 2^32)
    localparam int ACC_BITS      = POSITION_BITS + 34;
    localparam int ANGLE_SHIFT   = POSITION_BITS + 18;
    localparam int NUM_SHIFT     = POSITION_BITS + 1;
    localparam int POS_EXT       = POSITION_BITS + 2;

    localparam int ITER_MAX      = (POSITION_BITS > VEL_BITS) ? POSITION_BITS : VEL_BITS;
    localparam int CNT_BITS      = $clog2(ITER_MAX);

    localparam logic [ACC_BITS-1:0] PI_Q32  = ACC_BITS'(34'd13493037704);
    localparam logic [ACC_BITS-1:0] VEL_NUM = ACC_BITS'(22'd3216991);

    localparam logic signed [POS_EXT-1:0] POS_HALF_M1 =
        POS_EXT'((1 << (POSITION_BITS - 1)) - 1);
    localparam logic signed [POS_EXT-1:0] POS_FULL = POS_EXT'(1 << POSITION_BITS);

endpackage

`default_nettype wire

// ===== rtl/core/encoder_angle_velocity.sv =====
// ----------------------------------------------------------------------------
// Encoder angle and velocity
// Angle = position*pi (Q3.13); velocity = unwrapped delta / time delta (Q.8).
// Sequence: shift-add angle multiply, then, when velocity is computed, a shift-add
//   velocity multiply and a 21-step restoring divide, then the output register.
// A new request is taken only in idle (o_stall low); one shared adder/subtractor
//   serves angle multiply, velocity multiply and restoring divide.
// Reset: synchronous active-low; clears history, held velocity and control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_angle_velocity_assert.svh"

module encoder_angle_velocity (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output      logic                                  o_stall,
    input  wire logic [eav_pkg::POSITION_BITS-1:0]     i_position,
    input  wire logic [eav_pkg::TIME_BITS-1:0]         i_time_ms,
    output      logic                                  o_valid,
    input  wire logic                                  i_stall,
    output      logic [eav_pkg::ANGLE_BITS-1:0]        o_angle_rad_q13,
    output      logic signed [eav_pkg::VEL_BITS-1:0]   o_velocity_q8,
    output      logic                                  o_velocity_valid,
    output      logic                                  o_zero_interval
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ANG   = 3'd1;
    localparam logic [2:0] S_ASAVE = 3'd2;
    localparam logic [2:0] S_VMUL  = 3'd3;
    localparam logic [2:0] S_VLOAD = 3'd4;
    localparam logic [2:0] S_VDIV  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam int AB = eav_pkg::ACC_BITS;
    localparam int PB = eav_pkg::POSITION_BITS;
    localparam int VB = eav_pkg::VEL_BITS;
    localparam int TB = eav_pkg::TIME_BITS;

    logic [2:0]                       r_state;
    logic [eav_pkg::CNT_BITS-1:0]     r_cnt;
    logic [AB-1:0]                    r_acc;
    logic [AB-1:0]                    r_mcand;
    logic [PB-1:0]                    r_mplier;
    logic [VB-1:0]                    r_quo;
    logic [TB-1:0]                    r_dt;
    logic [PB-1:0]                    r_mag;
    logic                             r_neg;
    logic                             r_do_vel;
    logic                             r_zero;
    logic [eav_pkg::ANGLE_BITS-1:0]   r_angle;

    logic [PB-1:0]                    r_last_pos;
    logic [TB-1:0]                    r_last_time;
    logic                             r_have_prev;
    logic signed [VB-1:0]             r_held;

    logic                             r_out_valid;
    logic [eav_pkg::ANGLE_BITS-1:0]   r_out_angle;
    logic signed [VB-1:0]             r_out_vel;
    logic                             r_out_vvalid;
    logic                             r_out_zero;

    // request-side datapath
    logic                             req_take;
    logic [TB-1:0]                    n_dt;
    logic signed [eav_pkg::POS_EXT-1:0] d0, d1, d2, d_abs;

    // shared adder/subtractor
    logic [AB-1:0]                    su_a;
    logic [AB-1:0]                    su_b;
    logic                             su_sub;
    logic [AB:0]                      su_sum;
    logic                             div_geq;

    logic                             out_free;
    logic signed [VB-1:0]             n_vel;

    assign o_stall  = (r_state != S_IDLE);
    assign req_take = i_valid && !o_stall;

    assign n_dt = i_time_ms - r_last_time;

    always_comb begin
        d0 = $signed({2'b00, i_position}) - $signed({2'b00, r_last_pos});
        d1 = (d0 > eav_pkg::POS_HALF_M1) ? d0 - eav_pkg::POS_FULL : d0;
        d2 = (d1 < -eav_pkg::POS_HALF_M1) ? d1 + eav_pkg::POS_FULL : d1;
        d_abs = d2[eav_pkg::POS_EXT-1] ? -d2 : d2;
    end

    always_comb begin
        su_a   = '0;
        su_b   = '0;
        su_sub = 1'b0;
        case (r_state)
            S_ANG, S_VMUL: begin
                su_a = r_acc;
                su_b = r_mcand;
            end
            S_VDIV: begin
                su_a   = AB'({r_acc[TB-1:0], r_quo[VB-1]});
                su_b   = AB'(r_dt);
                su_sub = 1'b1;
            end
            default: begin
                su_sub = 1'b0;
            end
        endcase
        su_sum  = {1'b0, su_a} + ({1'b0, su_b} ^ {(AB+1){su_sub}}) + (AB+1)'(su_sub);
        div_geq = !su_sum[AB];
    end

    assign out_free = !r_out_valid || !i_stall;
    assign n_vel    = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
            r_last_pos  <= '0;
            r_last_time <= '0;
            r_held      <= '0;
            r_do_vel    <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_last_pos  <= i_position;
                        r_last_time <= i_time_ms;
                        r_have_prev <= 1'b1;
                        r_do_vel    <= r_have_prev && (n_dt != '0);
                        r_zero      <= r_have_prev && (n_dt == '0);
                        r_dt        <= n_dt;
                        r_neg       <= d2[eav_pkg::POS_EXT-1];
                        r_mag       <= d_abs[PB-1:0];
                        r_acc       <= '0;
                        r_mcand     <= eav_pkg::PI_Q32;
                        r_mplier    <= i_position;
                        r_cnt       <= eav_pkg::CNT_BITS'(PB - 1);
                        r_state     <= S_ANG;
                    end
                end
                S_ANG, S_VMUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= su_sum[AB-1:0];
                    end
                    r_mcand  <= {r_mcand[AB-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[PB-1:1]};
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= (r_state == S_ANG) ? S_ASAVE : S_VLOAD;
                    end
                end
                S_ASAVE: begin
                    r_angle <= r_acc[eav_pkg::ANGLE_SHIFT +: eav_pkg::ANGLE_BITS];
                    if (r_do_vel) begin
                        r_acc    <= '0;
                        r_mcand  <= eav_pkg::VEL_NUM;
                        r_mplier <= r_mag;
                        r_cnt    <= eav_pkg::CNT_BITS'(PB - 1);
                        r_state  <= S_VMUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_VLOAD: begin
                    // floor(mag / (dt << s)) == floor((mag >> s) / dt)
                    r_quo   <= r_acc[eav_pkg::NUM_SHIFT +: VB];
                    r_acc   <= '0;
                    r_cnt   <= eav_pkg::CNT_BITS'(VB - 1);
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    r_acc <= div_geq ? su_sum[AB-1:0] : su_a;
                    r_quo <= {r_quo[VB-2:0], div_geq};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_angle  <= r_angle;
                        r_out_vel    <= r_do_vel ? n_vel : r_held;
                        r_out_vvalid <= r_do_vel;
                        r_out_zero   <= r_zero;
                        if (r_do_vel) begin
                            r_held <= n_vel;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_angle_rad_q13  = r_out_angle;
    assign o_velocity_q8    = r_out_vel;
    assign o_velocity_valid = r_out_vvalid;
    assign o_zero_interval  = r_out_zero;

    `EAV_ASSERT(a_flags_exclusive, !(r_out_valid && r_out_vvalid && r_out_zero))
    `EAV_ASSERT(a_zero_skips_divide, !(r_zero && r_do_vel))
    `EAV_ASSERT(a_rem_below_dt, (r_state != S_VDIV) || (r_acc[TB-1:0] < r_dt))
    `EAV_ASSERT_NEXT(a_req_starts_angle, i_valid && !o_stall, r_state == S_ANG)

endmodule

`default_nettype wire
